FILE: sv/fic_pkg.sv
// Shared types and constants of the float/int conversion unit.
// No dependencies; every other file but fic_out_if imports this package.
package fic_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_I2F   = 2'd0;
    localparam op_t OP_F2I   = 2'd1;
    localparam op_t OP_FLOOR = 2'd2;

    // Exponent thresholds (biased)
    localparam logic [7:0] EXP_HALF  = 8'h7E;   // 0.5
    localparam logic [7:0] EXP_ONE   = 8'h7F;   // 1.0
    localparam logic [7:0] EXP_INT   = 8'h80;   // unused bias marker for 2.0
    localparam logic [7:0] EXP_EXACT = 8'd150;  // no fraction bits left
    localparam logic [7:0] EXP_TOP   = 8'd157;  // largest exponent that fits int32
    localparam logic [7:0] EXP_SAT   = 8'd158;  // 2^31 and up saturate

    localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;
    localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN   = 32'h8000_0000;
    localparam logic [31:0] NEG_ONE_F = 32'hBF80_0000;

    // Stage 1: unpacked operand
    typedef struct packed {
        op_t         op;
        logic        sign;
        logic        spec;       // result already known
        logic [31:0] spec_val;
        logic [31:0] data;       // magnitude (int to float) or raw operand
        logic [7:0]  expo;
    } s1_t;

    // Stage 2: shift amount resolved
    typedef struct packed {
        op_t         op;
        logic        sign;
        logic        spec;
        logic [31:0] spec_val;
        logic [31:0] data;
        logic [4:0]  shamt;
    } s2_t;

    // Stage 3: shifted word, ready for rounding
    typedef struct packed {
        op_t         op;
        logic        sign;
        logic        spec;
        logic [31:0] spec_val;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [4:0]  shamt;
        logic        frac_nz;
    } s3_t;

endpackage

FILE: sv/fic_in_if.sv
// Input channel of the conversion unit: op and operand with valid/ready.
// Depends on fic_pkg.
interface fic_in_if;
    import fic_pkg::*;

    logic        valid;
    logic        ready;
    op_t         op;
    logic [31:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

FILE: sv/fic_out_if.sv
// Output channel of the conversion unit: 32-bit result with valid/ready.
// No dependencies.
interface fic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

FILE: sv/float_int_conversion_unit.sv
// Float/int conversion unit: int32 to float, float to int32, float floor.
// The result word is held on the output register of the round stage.
// Throughput: one word per cycle; a stalled output holds each occupied stage in place.
// The four stages are unpack, normalize count, barrel shift, round and pack.
// Reset (rst_n, async, active low) empties the pipeline; no other state.
module float_int_conversion_unit (
    input  logic      clk,
    input  logic      rst_n,
    fic_in_if.sink    req,
    fic_out_if.source rsp
);
    import fic_pkg::*;

    logic v1, v2, v3, v4;
    logic adv1, adv2, adv3, adv4;
    s1_t  d1;
    s2_t  d2;
    s3_t  d3;

    // A stage moves when it is empty or the next one moves
    assign adv4 = !v4 || rsp.ready;
    assign adv3 = !v3 || adv4;
    assign adv2 = !v2 || adv3;
    assign adv1 = !v1 || adv2;

    assign req.ready = adv1;
    assign rsp.valid = v4;

    fic_unpack u_unpack (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv1),
        .in_valid   (req.valid),
        .in_op      (req.op),
        .in_operand (req.operand),
        .out_valid  (v1),
        .out_data   (d1)
    );

    fic_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv2),
        .in_valid  (v1),
        .in_data   (d1),
        .out_valid (v2),
        .out_data  (d2)
    );

    fic_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv3),
        .in_valid  (v2),
        .in_data   (d2),
        .out_valid (v3),
        .out_data  (d3)
    );

    fic_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv4),
        .in_valid   (v3),
        .in_data    (d3),
        .out_valid  (v4),
        .out_result (rsp.result)
    );
endmodule

FILE: sv/fic_unpack.sv
// Stage 1: field extraction, integer magnitude and special-case detection.
// Depends on fic_pkg.
module fic_unpack (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fic_pkg::op_t   in_op,
    input  logic [31:0]    in_operand,
    output logic           out_valid,
    output fic_pkg::s1_t   out_data
);
    import fic_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;
    logic sign;
    logic [7:0] expo;

    assign sign = in_operand[31];
    assign expo = in_operand[30:23];

    // Decode op and flag results that need no arithmetic
    always_comb
    begin
        data_next          = '0;
        data_next.op       = in_op;
        data_next.sign     = sign;
        data_next.expo     = expo;
        data_next.data     = in_operand;
        data_next.spec     = 1'b0;
        data_next.spec_val = '0;
        unique case (in_op)
            OP_I2F:
            begin
                data_next.data = sign ? (~in_operand + 32'd1) : in_operand;
                data_next.spec = (in_operand == 32'd0);
            end
            OP_F2I:
            begin
                if (expo < EXP_HALF)
                begin
                    data_next.spec = 1'b1;
                end
                else if (expo >= EXP_SAT)
                begin
                    data_next.spec     = 1'b1;
                    data_next.spec_val = sign ? INT_MIN : INT_MAX;
                end
            end
            OP_FLOOR:
            begin
                if (expo == 8'd0)
                begin
                    data_next.spec     = 1'b1;
                    data_next.spec_val = {sign, 31'd0};
                end
                else if (expo < EXP_ONE)
                begin
                    data_next.spec     = 1'b1;
                    data_next.spec_val = sign ? NEG_ONE_F : 32'd0;
                end
                else if (expo >= EXP_EXACT)
                begin
                    data_next.spec     = 1'b1;
                    data_next.spec_val = in_operand;
                end
            end
            default:
            begin
                data_next.spec = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: sv/fic_norm.sv
// Stage 2: leading-zero count for int to float, shift amounts for the others.
// Depends on fic_pkg.
module fic_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fic_pkg::s1_t   in_data,
    output logic           out_valid,
    output fic_pkg::s2_t   out_data
);
    import fic_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    logic [4:0] lz;
    logic [7:0] f2i_sh;
    logic [7:0] floor_sh;

    // Priority encoder: highest set bit wins
    always_comb
    begin
        lz = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (in_data.data[i])
                lz = 5'(31 - i);
        end
    end

    assign f2i_sh   = EXP_TOP - in_data.expo;
    assign floor_sh = in_data.expo - EXP_ONE;

    always_comb
    begin
        data_next          = '0;
        data_next.op       = in_data.op;
        data_next.sign     = in_data.sign;
        data_next.spec     = in_data.spec;
        data_next.spec_val = in_data.spec_val;
        data_next.data     = in_data.data;
        unique case (in_data.op)
            OP_I2F:   data_next.shamt = lz;
            OP_F2I:   data_next.shamt = f2i_sh[4:0];
            OP_FLOOR: data_next.shamt = floor_sh[4:0];
            default:  data_next.shamt = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: sv/fic_shift.sv
// Stage 3: barrel shifts (normalize, align to integer point, fraction mask).
// Depends on fic_pkg.
module fic_shift (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fic_pkg::s2_t   in_data,
    output logic           out_valid,
    output fic_pkg::s3_t   out_data
);
    import fic_pkg::*;

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;
    logic [63:0] align;
    logic [22:0] mask;
    logic [30:0] trunc;
    logic [23:0] addend;

    // Integer bits land in [63:32], fraction in [31:0]
    assign align  = {1'b0, 1'b1, in_data.data[22:0], 39'd0} >> in_data.shamt;
    assign mask   = FRAC_MASK[22:0] >> in_data.shamt;
    assign trunc  = in_data.data[30:0] & ~{8'd0, mask};
    assign addend = {1'b0, mask} + 24'd1;

    always_comb
    begin
        data_next          = '0;
        data_next.op       = in_data.op;
        data_next.sign     = in_data.sign;
        data_next.spec     = in_data.spec;
        data_next.spec_val = in_data.spec_val;
        data_next.shamt    = in_data.shamt;
        unique case (in_data.op)
            OP_I2F:
            begin
                data_next.hi = in_data.data << in_data.shamt;
            end
            OP_F2I:
            begin
                data_next.hi = align[63:32];
                data_next.lo = align[31:0];
            end
            OP_FLOOR:
            begin
                data_next.hi      = {in_data.sign, trunc};
                data_next.lo      = {8'd0, addend};
                data_next.frac_nz = |(in_data.data[22:0] & mask);
            end
            default:
            begin
                data_next.hi = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: sv/fic_round.sv
// Stage 4: ties-to-even rounding, packing and the output register.
// Depends on fic_pkg.
module fic_round (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fic_pkg::s3_t   in_data,
    output logic           out_valid,
    output logic [31:0]    out_result
);
    import fic_pkg::*;

    logic        valid_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic        i2f_inc;
    logic [7:0]  i2f_exp;
    logic [31:0] i2f_res;
    logic        f2i_inc;
    logic [31:0] f2i_res;
    logic [31:0] floor_res;

    // Int to float: exponent field minus one plus significand with hidden bit
    assign i2f_inc = in_data.hi[7] & ((|in_data.hi[6:0]) | in_data.hi[8]);
    assign i2f_exp = EXP_TOP - {3'd0, in_data.shamt};
    assign i2f_res = {in_data.sign, 31'd0}
                   | ({1'b0, i2f_exp, 23'd0} + {8'd0, in_data.hi[31:8]}
                      + {31'd0, i2f_inc});

    // Float to int: -(m + inc) folded into ~m + !inc
    assign f2i_inc = in_data.lo[31] & ((|in_data.lo[30:0]) | in_data.hi[0]);
    assign f2i_res = in_data.sign ? (~in_data.hi + {31'd0, ~f2i_inc})
                                  : (in_data.hi + {31'd0, f2i_inc});

    // Floor: negatives with a fraction step up in magnitude
    assign floor_res = (in_data.frac_nz && in_data.sign)
                     ? {1'b1, in_data.hi[30:0] + in_data.lo[30:0]}
                     : in_data.hi;

    always_comb
    begin
        if (in_data.spec)
            result_next = in_data.spec_val;
        else
        begin
            unique case (in_data.op)
                OP_I2F:   result_next = i2f_res;
                OP_F2I:   result_next = f2i_res;
                OP_FLOOR: result_next = floor_res;
                default:  result_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
endmodule
